[rtl/bresenham_line_rasterizer_unit_macros.svh]
// Assertion macros for the rasteriser top module
`ifndef BRESENHAM_LINE_RASTERIZER_UNIT_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds in the same cycle as the trigger
`define BLR_ASSERT_SAME(lbl, clock, resetn, trig, cond) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (trig) |-> (cond)) \
        else $error("rasteriser check failed");

// Condition holds in the cycle after the trigger
`define BLR_ASSERT_NEXT(lbl, clock, resetn, trig, cond) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (trig) |=> (cond)) \
        else $error("rasteriser check failed");

`else

`define BLR_ASSERT_SAME(lbl, clock, resetn, trig, cond)
`define BLR_ASSERT_NEXT(lbl, clock, resetn, trig, cond)

`endif

`endif

[rtl/blr_pkg.sv]
package blr_pkg;

    // Coordinate and register widths
    localparam int COORD_W  = 6;
    localparam int CANVAS_W = 7;
    localparam int ERR_W    = 10;

    // Canvas size after reset
    localparam int MAX_DIM = 64;
    localparam logic [CANVAS_W-1:0] CANVAS_RESET = CANVAS_W'(MAX_DIM & 127);

    // Default number of commands queued between front end and walker
    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration register indexes
    localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;

    // Result status codes
    localparam logic [1:0] STATUS_PIXEL = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    // One classified command, ready for the walker
    typedef struct packed {
        logic [1:0]              kind;
        logic                    x_major;
        logic                    minor_neg;
        logic                    pen;
        logic [COORD_W-1:0]      cur_major;
        logic [COORD_W-1:0]      cur_minor;
        logic [COORD_W-1:0]      end_major;
        logic signed [ERR_W-1:0] err;
        logic signed [ERR_W-1:0] inc_step;
        logic signed [ERR_W-1:0] inc_hold;
    } job_t;

    // One result item
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               value;
        logic [1:0]         status;
        logic               last;
    } result_t;

endpackage

[rtl/blr_front.sv]
module blr_front
    import blr_pkg::*;
(
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,
    input  logic [CANVAS_W-1:0] canvas_width,
    input  logic [CANVAS_W-1:0] canvas_height,
    input  logic                queue_full,
    output logic                push,
    output job_t                job
);

    logic [COORD_W-1:0] sx, sy, ex, ey;
    logic               pen;
    logic               outside;
    logic [COORD_W-1:0] adx, ady;
    logic               x_major, swap;
    logic [COORD_W-1:0] p0x, p0y, p1x, p1y;
    logic [COORD_W-1:0] a0, a1, b0, b1;
    logic [COORD_W-1:0] dmaj, dmin;
    logic               neg;
    logic [ERR_W-1:0]   dmin2, dmaj1, dmaj2;

    // Field unpacking
    assign sx  = s_tdata[5:0];
    assign sy  = s_tdata[11:6];
    assign ex  = s_tdata[17:12];
    assign ey  = s_tdata[23:18];
    assign pen = s_tdata[24];

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    // Canvas check on the endpoints as given
    assign outside = ({1'b0, sx} >= canvas_width)  || ({1'b0, ex} >= canvas_width) ||
                     ({1'b0, sy} >= canvas_height) || ({1'b0, ey} >= canvas_height);

    // Major axis selection, ties go to y
    assign adx     = (sx > ex) ? (sx - ex) : (ex - sx);
    assign ady     = (sy > ey) ? (sy - ey) : (ey - sy);
    assign x_major = ady < adx;

    // Order endpoints so the walk runs upward along the major axis
    assign swap = x_major ? (sx > ex) : (sy > ey);
    assign p0x  = swap ? ex : sx;
    assign p0y  = swap ? ey : sy;
    assign p1x  = swap ? sx : ex;
    assign p1y  = swap ? sy : ey;

    assign a0 = x_major ? p0x : p0y;
    assign a1 = x_major ? p1x : p1y;
    assign b0 = x_major ? p0y : p0x;
    assign b1 = x_major ? p1y : p1x;

    // Deltas and error increments
    assign dmaj  = a1 - a0;
    assign neg   = b1 < b0;
    assign dmin  = neg ? (b0 - b1) : (b1 - b0);
    assign dmin2 = {3'b000, dmin, 1'b0};
    assign dmaj1 = {4'b0000, dmaj};
    assign dmaj2 = {3'b000, dmaj, 1'b0};

    always_comb
    begin
        job.kind      = outside ? STATUS_ERROR
                      : ((dmaj == '0) ? STATUS_EMPTY : STATUS_PIXEL);
        job.x_major   = x_major;
        job.minor_neg = neg;
        job.pen       = pen;
        job.cur_major = a0;
        job.cur_minor = b0;
        job.end_major = a1;
        job.err       = $signed(dmin2 - dmaj1);
        job.inc_step  = $signed(dmin2 - dmaj2);
        job.inc_hold  = $signed(dmin2);
    end

endmodule

[rtl/blr_queue.sv]
module blr_queue
    import blr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic empty,
    output logic full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[rtl/blr_walk.sv]
module blr_walk
    import blr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_empty,
    input  job_t        job,
    output logic        job_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    logic    busy_reg, busy_next;
    job_t    cur_reg, cur_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    slot_free;
    logic    pix_last, err_pos;
    result_t res;

    assign slot_free = !out_valid_reg || m_tready;
    assign job_pop   = !busy_reg && !job_empty;
    assign pix_last  = (cur_reg.cur_major + 1'b1) == cur_reg.end_major;
    assign err_pos   = cur_reg.err > 0;

    // Result for the current walk position
    always_comb
    begin
        res = '0;
        if (cur_reg.kind == STATUS_PIXEL)
        begin
            res.x      = cur_reg.x_major ? cur_reg.cur_major : cur_reg.cur_minor;
            res.y      = cur_reg.x_major ? cur_reg.cur_minor : cur_reg.cur_major;
            res.value  = cur_reg.pen;
            res.status = STATUS_PIXEL;
            res.last   = pix_last;
        end
        else
        begin
            res.status = cur_reg.kind;
            res.last   = 1'b1;
        end
    end

    // Walker step and output register
    always_comb
    begin
        busy_next      = busy_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (job_pop)
        begin
            cur_next  = job;
            busy_next = 1'b1;
        end
        if (busy_reg && slot_free)
        begin
            out_valid_next     = 1'b1;
            out_next           = res;
            cur_next.cur_major = cur_reg.cur_major + 1'b1;
            if (err_pos)
            begin
                cur_next.cur_minor = cur_reg.minor_neg ? cur_reg.cur_minor - 1'b1
                                                       : cur_reg.cur_minor + 1'b1;
                cur_next.err       = cur_reg.err + cur_reg.inc_step;
            end
            else
            begin
                cur_next.err = cur_reg.err + cur_reg.inc_hold;
            end
            if (res.last)
            begin
                busy_next = 1'b0;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.value, out_reg.y, out_reg.x};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

endmodule

[rtl/bresenham_line_rasterizer_unit.sv]
// Bresenham line rasteriser. Each command (two endpoints and a pen value) is
// checked against the canvas and classified by the front end, then queued for
// the walker, which emits one pixel transfer per cycle while the output is
// taken. The walker loads a command, then steps along its major axis; a line
// of major length n gives n pixels, and an out-of-canvas or zero-length
// command gives a single status result. The single walker, stepping one pixel
// per cycle while the output is taken, sets the throughput; the front end
// takes one command per cycle while the queue of QUEUE_DEPTH commands has
// room. The far endpoint is not drawn; every command ends with tlast set on
// its final result, and the result kind travels on tuser.
`include "bresenham_line_rasterizer_unit_macros.svh"

module bresenham_line_rasterizer_unit
    import blr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // start_x, start_y, end_x, end_y, pen, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pixel_x, pixel_y, pixel_value, zero fill
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    logic [CANVAS_W-1:0] canvas_width_reg;
    logic [CANVAS_W-1:0] canvas_height_reg;
    logic                push, pop, q_empty, q_full;
    job_t                push_job, pop_job;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= CANVAS_RESET;
            canvas_height_reg <= CANVAS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data;
                REG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    blr_front u_front (
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .canvas_width  (canvas_width_reg),
        .canvas_height (canvas_height_reg),
        .queue_full    (q_full),
        .push          (push),
        .job           (push_job)
    );

    blr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    blr_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (q_empty),
        .job       (pop_job),
        .job_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Status results stand alone, carry tlast and no coordinates
    `BLR_ASSERT_SAME(a_status_alone, clk, rst_n, m_tvalid && m_tuser != STATUS_PIXEL, m_tlast && m_tdata == '0)

    // A line keeps streaming: after a non-final transfer the next pixel is ready
    `BLR_ASSERT_NEXT(a_line_no_gap, clk, rst_n, m_tvalid && m_tready && !m_tlast, m_tvalid)

    // A line is not cut by a status result
    `BLR_ASSERT_NEXT(a_line_pixels, clk, rst_n, m_tvalid && m_tready && !m_tlast, m_tuser == STATUS_PIXEL)

endmodule
